/* design/gbn_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbn_pkg: shared types and constants of the go-back-N send window
// Window geometry, command and status codes, the result record and the
// circular pointer helper used by the sequencer.
// ----------------------------------------------------------------------------
package gbn_pkg;

    // Window and sequence geometry
    localparam int WINDOW_DEPTH = 8;
    localparam int SEQ_MODULUS  = 256;
    localparam int SEQ_W        = 8;
    localparam int PTR_W        = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int OCC_W        = $clog2(WINDOW_DEPTH + 1);
    localparam int CNT_W        = 8;
    localparam int HELD_W       = 4;

    // Command codes
    localparam logic [1:0] CMD_PUSH    = 2'd0;
    localparam logic [1:0] CMD_RECV    = 2'd1;
    localparam logic [1:0] CMD_RESEND  = 2'd2;
    localparam logic [1:0] CMD_TIMEOUT = 2'd3;

    // Status codes
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_FULL    = 2'd1;
    localparam logic [1:0] STAT_NOT_ACK = 2'd2;
    localparam logic [1:0] STAT_GAVE_UP = 2'd3;

    // Configuration register indexes
    localparam logic REG_START_SEQ = 1'b0;
    localparam logic REG_TRY_LIMIT = 1'b1;

    localparam logic [CNT_W-1:0] TRY_LIMIT_RESET = CNT_W'(10);
    localparam logic [CNT_W-1:0] TRY_SAT         = {CNT_W{1'b1}};

    // One result record
    typedef struct packed {
        logic [SEQ_W-1:0]  seq_id;
        logic              is_send;
        logic              last;
        logic [1:0]        status;
        logic [HELD_W-1:0] held;
    } res_t;

    // Add two window pointers modulo the window depth
    function automatic logic [PTR_W-1:0] ptr_add(logic [PTR_W-1:0] a, logic [PTR_W-1:0] b);
        logic [PTR_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (PTR_W+1)'(WINDOW_DEPTH)) begin
            s = s - (PTR_W+1)'(WINDOW_DEPTH);
        end
        return s[PTR_W-1:0];
    endfunction

endpackage

/* design/gbn_out_reg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbn_out_reg: result output register
// Holds one result request for the master side and frees the slot when the
// request is taken, so the sequencer can run on while a result waits.
// ----------------------------------------------------------------------------
module gbn_out_reg
    import gbn_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        load,
    input  res_t        res,
    output logic        free,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // seq_id[7:0], is_send[8], held[12:9], zero[15:13]
    output logic        m_tlast,
    output logic [1:0]  m_tuser    // status[1:0]
);

    logic valid_reg;
    logic valid_next;
    res_t res_reg;

    // Slot is free when empty or being drained this cycle
    assign free = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Capture payload on load
    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {3'b000, res_reg.held, res_reg.is_send, res_reg.seq_id};
    assign m_tlast  = res_reg.last;
    assign m_tuser  = res_reg.status;

endmodule

/* design/go_back_n_send_window.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// go_back_n_send_window: sender side of a go-back-N sliding window
// Push, cumulative ack, resend round and round timeout on a circular window.
// ----------------------------------------------------------------------------
// Handling: push, non-ack packet and timeout are done in the execute state, and
//   their result is registered in the output slot; an ack reads and compares entries in turn.
// Flow: one request at a time; a resend round emits the held numbers oldest first,
//   each through a read state and an emit state, waiting while the output slot is busy.
// Reset (aresetn low, synchronous): window empty, next number 0, tries 0,
//   try limit 10; window entries themselves are not cleared.
module go_back_n_send_window
    import gbn_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [7:0]  cfg_wdata,
    // request input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // ack_id[7:0]
    input  logic [2:0]  s_tuser,    // cmd[1:0], ack_flag[2]
    // result output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // seq_id[7:0], is_send[8], held[12:9], zero[15:13]
    output logic        m_tlast,
    output logic [1:0]  m_tuser     // status[1:0]
);

    // Sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_SREAD = 3'd2;
    localparam logic [2:0] S_SCMP  = 3'd3;
    localparam logic [2:0] S_ACKD  = 3'd4;
    localparam logic [2:0] S_RREAD = 3'd5;
    localparam logic [2:0] S_REMIT = 3'd6;

    logic [2:0]       state_reg, state_next;
    logic [OCC_W-1:0] occ_reg, occ_next;
    logic [PTR_W-1:0] head_reg, head_next;
    logic [OCC_W-1:0] idx_reg, idx_next;
    logic [SEQ_W-1:0] next_seq_reg, next_seq_next;
    logic [CNT_W-1:0] try_reg, try_next;
    logic [CNT_W-1:0] max_att_reg;

    logic [1:0]       cmd_reg;
    logic [7:0]       ack_id_reg;
    logic             ack_flag_reg;

    logic [SEQ_W-1:0] win_mem [WINDOW_DEPTH];
    logic [SEQ_W-1:0] rd_data_reg;
    logic [PTR_W-1:0] rd_addr;
    logic [PTR_W-1:0] wr_addr;
    logic             wr_en;

    logic             out_free;
    logic             out_load;
    res_t             out_res;

    logic             accept;
    logic [CNT_W-1:0] try_inc;
    logic [OCC_W-1:0] idx_inc;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign idx_inc  = idx_reg + OCC_W'(1);
    assign try_inc  = (try_reg == TRY_SAT) ? try_reg : try_reg + CNT_W'(1);
    assign rd_addr  = ptr_add(head_reg, idx_reg[PTR_W-1:0]);
    assign wr_addr  = ptr_add(head_reg, occ_reg[PTR_W-1:0]);

    // Window store: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            win_mem[wr_addr] <= next_seq_reg;
        end
        rd_data_reg <= win_mem[rd_addr];
    end

    // Sequencer
    always_comb begin
        state_next    = state_reg;
        occ_next      = occ_reg;
        head_next     = head_reg;
        idx_next      = idx_reg;
        next_seq_next = next_seq_reg;
        try_next      = try_reg;
        wr_en         = 1'b0;
        out_load      = 1'b0;
        out_res       = '0;
        out_res.last  = 1'b1;
        out_res.held  = HELD_W'(occ_reg);

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    idx_next   = '0;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (cmd_reg)
                    CMD_PUSH: begin
                        if (out_free) begin
                            out_load = 1'b1;
                            if (occ_reg >= OCC_W'(WINDOW_DEPTH)) begin
                                out_res.status = STAT_FULL;
                            end else begin
                                wr_en          = 1'b1;
                                occ_next       = occ_reg + OCC_W'(1);
                                next_seq_next  = (next_seq_reg == SEQ_W'(SEQ_MODULUS - 1)) ?
                                                 '0 : next_seq_reg + SEQ_W'(1);
                                out_res.seq_id  = next_seq_reg;
                                out_res.is_send = 1'b1;
                                out_res.held    = HELD_W'(occ_reg + OCC_W'(1));
                            end
                            state_next = S_IDLE;
                        end
                    end
                    CMD_RECV: begin
                        if (!ack_flag_reg) begin
                            if (out_free) begin
                                out_load       = 1'b1;
                                out_res.seq_id = ack_id_reg;
                                out_res.status = STAT_NOT_ACK;
                                state_next     = S_IDLE;
                            end
                        end else begin
                            try_next   = '0;
                            state_next = (occ_reg == '0) ? S_ACKD : S_SREAD;
                        end
                    end
                    CMD_RESEND: begin
                        if (occ_reg == '0) begin
                            if (out_free) begin
                                out_load   = 1'b1;
                                state_next = S_IDLE;
                            end
                        end else begin
                            state_next = S_RREAD;
                        end
                    end
                    CMD_TIMEOUT: begin
                        if (out_free) begin
                            out_load       = 1'b1;
                            try_next       = try_inc;
                            out_res.status = (try_inc >= max_att_reg) ? STAT_GAVE_UP : STAT_OK;
                            state_next     = S_IDLE;
                        end
                    end
                    default: ;
                endcase
            end
            // Fetch the entry at idx for comparison
            S_SREAD: begin
                state_next = S_SCMP;
            end
            // Compare, drop matched entry and all older ones, advance, or stop at the window end
            S_SCMP: begin
                if (rd_data_reg == ack_id_reg) begin
                    head_next  = ptr_add(rd_addr, PTR_W'(1));
                    occ_next   = occ_reg - idx_inc;
                    state_next = S_ACKD;
                end else if (idx_inc == occ_reg) begin
                    state_next = S_ACKD;
                end else begin
                    idx_next   = idx_inc;
                    state_next = S_SREAD;
                end
            end
            S_ACKD: begin
                if (out_free) begin
                    out_load       = 1'b1;
                    out_res.seq_id = ack_id_reg;
                    state_next     = S_IDLE;
                end
            end
            S_RREAD: begin
                state_next = S_REMIT;
            end
            // Emit one held number, oldest first
            S_REMIT: begin
                if (out_free) begin
                    out_load        = 1'b1;
                    out_res.seq_id  = rd_data_reg;
                    out_res.is_send = 1'b1;
                    out_res.last    = (idx_inc == occ_reg);
                    if (idx_inc == occ_reg) begin
                        state_next = S_IDLE;
                    end else begin
                        idx_next   = idx_inc;
                        state_next = S_RREAD;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers and configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            occ_reg      <= '0;
            head_reg     <= '0;
            idx_reg      <= '0;
            next_seq_reg <= '0;
            try_reg      <= '0;
            max_att_reg  <= TRY_LIMIT_RESET;
        end else begin
            state_reg <= state_next;
            occ_reg   <= occ_next;
            head_reg  <= head_next;
            idx_reg   <= idx_next;
            try_reg   <= try_next;
            if (cfg_we && cfg_addr == REG_START_SEQ) begin
                next_seq_reg <= SEQ_W'(cfg_wdata);
            end else begin
                next_seq_reg <= next_seq_next;
            end
            if (cfg_we && cfg_addr == REG_TRY_LIMIT) begin
                max_att_reg <= cfg_wdata;
            end
        end
    end

    // Latch the request payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg      <= s_tuser[1:0];
            ack_flag_reg <= s_tuser[2];
            ack_id_reg   <= s_tdata;
        end
    end

    gbn_out_reg u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (out_load),
        .res      (out_res),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // Checks
    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg <= OCC_W'(WINDOW_DEPTH))
        else $error("window occupancy above depth");

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> out_free)
        else $error("result loaded into a busy output slot");

    a_push_grow: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EXEC && cmd_reg == CMD_PUSH && out_free &&
         occ_reg < OCC_W'(WINDOW_DEPTH))
        |=> occ_reg == $past(occ_reg) + OCC_W'(1))
        else $error("accepted push did not grow the window");

    a_ack_clears_try: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EXEC && cmd_reg == CMD_RECV && ack_flag_reg) |=> try_reg == '0)
        else $error("ack did not clear the try count");

endmodule

/* tb/go_back_n_send_window_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// go_back_n_send_window_tb: self-checking bench for the go-back-N send window
// Drives push, receive, resend and timeout requests through the request
// stream. Every accepted request is run through a local window predictor,
// and each result taken from the result stream is compared field by field
// with the oldest predicted result. A short directed table comes first.
// It is followed by random phases under several register settings, with
// random gaps on both streams, one long result stall and sender pauses.
// ----------------------------------------------------------------------------
module go_back_n_send_window_tb
    import gbn_pkg::*;
();

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 24;
    localparam int LONG_STALL   = 300;
    localparam int PHASE_ITEMS  = 22;
    localparam int DIR_ROWS     = 24;

    // One row of the directed stimulus
    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] ack_id;
        logic       ack_flag;
        logic       known;
        res_t       want;
    } dir_row_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic        cfg_addr  = 1'b0;
    logic [7:0]  cfg_wdata = 8'd0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'd0;    // ack_id[7:0]
    logic [2:0]  s_tuser   = 3'd0;    // cmd[1:0], ack_flag[2]
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;             // seq_id[7:0], is_send[8], held[12:9], zero[15:13]
    logic        m_tlast;
    logic [1:0]  m_tuser;             // status[1:0]

    // Predicted window state and registers
    logic [7:0] win_ids [WINDOW_DEPTH];
    int         win_count   = 0;
    int         seq_next    = 0;
    int         tries       = 0;
    logic [7:0] max_tries   = TRY_LIMIT_RESET;

    res_t       step_results [$];
    res_t       pending_results [$];
    int         mismatches  = 0;
    int         cycles      = 0;
    bit         tx_quiet    = 1'b0;
    bit         rx_quiet    = 1'b0;
    bit         rx_long_hold = 1'b0;
    dir_row_t   dir_rows [DIR_ROWS];

    go_back_n_send_window dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic res_t make_res(logic [7:0] seq, logic snd, logic lst,
                                      logic [1:0] st, logic [3:0] hld);
        res_t r;
        r.seq_id  = seq;
        r.is_send = snd;
        r.last    = lst;
        r.status  = st;
        r.held    = hld;
        return r;
    endfunction

    function automatic dir_row_t free_row(logic [1:0] cmd, logic [7:0] id, logic flag);
        return '{cmd: cmd, ack_id: id, ack_flag: flag, known: 1'b0, want: '0};
    endfunction

    function automatic dir_row_t known_row(logic [1:0] cmd, logic [7:0] id, logic flag,
                                           logic [7:0] seq, logic snd, logic [1:0] st,
                                           logic [3:0] hld);
        return '{cmd: cmd, ack_id: id, ack_flag: flag, known: 1'b1,
                 want: make_res(seq, snd, 1'b1, st, hld)};
    endfunction

    function automatic void emit(logic [7:0] seq, logic snd, logic lst, logic [1:0] st);
        step_results.insert(step_results.size(),
                            make_res(seq, snd, lst, st, HELD_W'(win_count)));
    endfunction

    // Work out the results of one request and advance the predicted window
    function automatic void predict_window(logic [1:0] cmd, logic [7:0] id, logic flag);
        int hit;
        step_results.delete();
        case (cmd)
            CMD_PUSH: begin
                if (win_count >= WINDOW_DEPTH) begin
                    emit(8'd0, 1'b0, 1'b1, STAT_FULL);
                end else begin
                    win_ids[win_count] = 8'(seq_next);
                    win_count++;
                    emit(8'(seq_next), 1'b1, 1'b1, STAT_OK);
                    seq_next = (seq_next + 1) % SEQ_MODULUS;
                end
            end
            CMD_RECV: begin
                if (!flag) begin
                    emit(id, 1'b0, 1'b1, STAT_NOT_ACK);
                end else begin
                    tries = 0;
                    hit = -1;
                    for (int i = 0; i < win_count; i++) begin
                        if (hit < 0 && win_ids[i] == id) hit = i;
                    end
                    // drop the matching entry and everything older
                    if (hit >= 0) begin
                        for (int j = hit + 1; j < win_count; j++) begin
                            win_ids[j - hit - 1] = win_ids[j];
                        end
                        win_count -= hit + 1;
                    end
                    emit(id, 1'b0, 1'b1, STAT_OK);
                end
            end
            CMD_RESEND: begin
                if (win_count == 0) begin
                    emit(8'd0, 1'b0, 1'b1, STAT_OK);
                end else begin
                    for (int i = 0; i < win_count; i++) begin
                        emit(win_ids[i], 1'b1, i == win_count - 1, STAT_OK);
                    end
                end
            end
            default: begin
                if (tries < 255) tries++;
                emit(8'd0, 1'b0, 1'b1, (tries >= max_tries) ? STAT_GAVE_UP : STAT_OK);
            end
        endcase
    endfunction

    // Offer one request after a random gap and queue its results once taken
    task automatic offer_request(input logic [1:0] cmd, input logic [7:0] id,
                                 input logic flag, input logic known, input res_t want);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= id;
        s_tuser  <= {flag, cmd};
        do @(posedge aclk); while (!s_tready);
        predict_window(cmd, id, flag);
        if (known) begin
            pending_results.insert(pending_results.size(), want);
        end else begin
            foreach (step_results[k]) begin
                pending_results.insert(pending_results.size(), step_results[k]);
            end
        end
    endtask

    // Mostly well-formed traffic: acks usually name a held number
    task automatic offer_random_request();
        int         pick;
        logic [1:0] cmd;
        logic [7:0] id;
        logic       flag;
        pick = $urandom_range(0, 99);
        id   = 8'($urandom);
        flag = 1'($urandom);
        if (pick < 35) begin
            cmd = CMD_PUSH;
        end else if (pick < 70) begin
            cmd  = CMD_RECV;
            flag = ($urandom_range(0, 4) != 0);
            if (win_count > 0 && $urandom_range(0, 2) != 0) begin
                id = win_ids[$urandom_range(0, win_count - 1)];
            end
        end else if (pick < 85) begin
            cmd = CMD_RESEND;
        end else begin
            cmd = CMD_TIMEOUT;
        end
        offer_request(cmd, id, flag, 1'b0, '0);
    endtask

    // Stop offering and wait until every predicted result has been taken
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == REG_START_SEQ) begin
            seq_next = val % SEQ_MODULUS;
        end else begin
            max_tries = val;
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Result side: random stalls, one long hold-off when asked
    initial begin
        int gap;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (rx_long_hold) begin
                m_tready <= 1'b0;
                repeat (LONG_STALL) @(posedge aclk);
                rx_long_hold = 1'b0;
            end
            gap = rx_quiet ? 0 : $urandom_range(0, 9);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
        end
    end

    // Compare each taken result with the oldest prediction
    always @(posedge aclk) begin
        res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual seq %0d status %0d",
                         $time, m_tdata[7:0], m_tuser);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                check_field("seq_id", want.seq_id, m_tdata[7:0]);
                check_field("is_send", want.is_send, m_tdata[8]);
                check_field("held", want.held, m_tdata[12:9]);
                check_field("pad", 0, m_tdata[15:13]);
                check_field("last", want.last, m_tlast);
                check_field("status", want.status, m_tuser);
            end
        end
    end

    // Guard against a hung run
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("go_back_n_send_window test failed");
            $finish;
        end
    end

    initial begin
        dir_rows = '{
            known_row(CMD_RESEND,  8'h00, 1'b0, 8'h00, 1'b0, STAT_OK,      4'd0),
            known_row(CMD_RECV,    8'hFF, 1'b0, 8'hFF, 1'b0, STAT_NOT_ACK, 4'd0),
            known_row(CMD_RECV,    8'h00, 1'b1, 8'h00, 1'b0, STAT_OK,      4'd0),
            known_row(CMD_TIMEOUT, 8'hA5, 1'b1, 8'h00, 1'b0, STAT_OK,      4'd0),
            known_row(CMD_TIMEOUT, 8'h5A, 1'b0, 8'h00, 1'b0, STAT_GAVE_UP, 4'd0),
            known_row(CMD_TIMEOUT, 8'hFF, 1'b1, 8'h00, 1'b0, STAT_GAVE_UP, 4'd0),
            known_row(CMD_PUSH,    8'h00, 1'b0, 8'hFA, 1'b1, STAT_OK,      4'd1),
            known_row(CMD_PUSH,    8'hFF, 1'b1, 8'hFB, 1'b1, STAT_OK,      4'd2),
            known_row(CMD_PUSH,    8'h00, 1'b0, 8'hFC, 1'b1, STAT_OK,      4'd3),
            known_row(CMD_PUSH,    8'hFF, 1'b1, 8'hFD, 1'b1, STAT_OK,      4'd4),
            known_row(CMD_PUSH,    8'h00, 1'b0, 8'hFE, 1'b1, STAT_OK,      4'd5),
            known_row(CMD_PUSH,    8'hFF, 1'b1, 8'hFF, 1'b1, STAT_OK,      4'd6),
            known_row(CMD_PUSH,    8'h00, 1'b0, 8'h00, 1'b1, STAT_OK,      4'd7),
            known_row(CMD_PUSH,    8'hFF, 1'b1, 8'h01, 1'b1, STAT_OK,      4'd8),
            known_row(CMD_PUSH,    8'h55, 1'b0, 8'h00, 1'b0, STAT_FULL,    4'd8),
            free_row (CMD_RESEND,  8'hAA, 1'b1),
            known_row(CMD_RECV,    8'h80, 1'b1, 8'h80, 1'b0, STAT_OK,      4'd8),
            known_row(CMD_TIMEOUT, 8'h00, 1'b0, 8'h00, 1'b0, STAT_OK,      4'd8),
            known_row(CMD_RECV,    8'hFC, 1'b0, 8'hFC, 1'b0, STAT_NOT_ACK, 4'd8),
            free_row (CMD_RECV,    8'hFC, 1'b1),
            free_row (CMD_RESEND,  8'h00, 1'b0),
            free_row (CMD_PUSH,    8'h7F, 1'b1),
            free_row (CMD_RECV,    8'h02, 1'b1),
            known_row(CMD_RESEND,  8'hFF, 1'b0, 8'h00, 1'b0, STAT_OK,      4'd0)
        };

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part: start near the wrap, give up after two silent rounds
        write_reg(REG_START_SEQ, 8'd250);
        write_reg(REG_TRY_LIMIT, 8'd2);
        foreach (dir_rows[r]) begin
            offer_request(dir_rows[r].cmd, dir_rows[r].ack_id, dir_rows[r].ack_flag,
                          dir_rows[r].known, dir_rows[r].want);
        end

        // Random phases under different register settings
        for (int ph = 0; ph < 4; ph++) begin
            wait_drained();
            repeat (DRAIN_CYCLES) @(posedge aclk);
            case (ph)
                0: begin
                    write_reg(REG_START_SEQ, 8'd0);
                    write_reg(REG_TRY_LIMIT, 8'd1);
                    tx_quiet = 1'b0;
                    rx_quiet = 1'b0;
                end
                1: begin
                    write_reg(REG_START_SEQ, 8'd255);
                    write_reg(REG_TRY_LIMIT, 8'd255);
                    tx_quiet = 1'b1;
                    rx_quiet = 1'b0;
                    rx_long_hold = 1'b1;
                end
                2: begin
                    write_reg(REG_START_SEQ, 8'($urandom_range(1, 254)));
                    write_reg(REG_TRY_LIMIT, 8'd0);
                    tx_quiet = 1'b0;
                    rx_quiet = 1'b1;
                end
                default: begin
                    write_reg(REG_START_SEQ, 8'($urandom));
                    write_reg(REG_TRY_LIMIT, 8'($urandom_range(1, 254)));
                    tx_quiet = 1'b1;
                    rx_quiet = 1'b1;
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // hold off now and then until the window has drained its results
                if (n == PHASE_ITEMS / 2 || $urandom_range(0, 15) == 0) wait_drained();
                offer_random_request();
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("go_back_n_send_window test passed");
        end else begin
            $display("go_back_n_send_window test failed");
        end
        $finish;
    end

endmodule
